// ===== rtl/core/ltm_pkg.sv =====
// Shared types and codes of the lock table manager.
`timescale 1ns / 1ps

package ltm_pkg;

    // Status codes returned to the requester
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RETRY = 2'd1;
    localparam logic [1:0] ST_NOENT = 2'd2;

    // Message kinds sent to a client
    localparam logic [1:0] MSG_NONE   = 2'd0;
    localparam logic [1:0] MSG_REVOKE = 2'd1;
    localparam logic [1:0] MSG_RETRY  = 2'd2;

    // Request opcodes
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Control states of the table sequencer
    typedef enum logic [2:0] {
        S_CLEAR  = 3'b001,
        S_IDLE   = 3'b010,
        S_MODIFY = 3'b100
    } ltm_state_t;

    // Status and message kind of one result
    typedef struct packed {
        logic [1:0] status;
        logic [1:0] kind;
    } result_code_t;

endpackage

// ===== rtl/core/ltm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ltm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port: hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ltm_update.sv =====
// Next-entry and result logic for one acquire or release on a table entry.
`timescale 1ns / 1ps

module ltm_update #(
    parameter int CLIENT_COUNT = 16
) (
    input  logic                            opcode,
    input  logic                            in_range,
    input  logic [$clog2(CLIENT_COUNT)-1:0] client,
    input  logic                            cur_exists,
    input  logic                            cur_held,
    input  logic [$clog2(CLIENT_COUNT)-1:0] cur_owner,
    input  logic [CLIENT_COUNT-1:0]         cur_waiters,
    output logic                            new_exists,
    output logic                            new_held,
    output logic [$clog2(CLIENT_COUNT)-1:0] new_owner,
    output logic [CLIENT_COUNT-1:0]         new_waiters,
    output logic                            write_en,
    output ltm_pkg::result_code_t           code,
    output logic [$clog2(CLIENT_COUNT)-1:0] target
);

    localparam int CW = $clog2(CLIENT_COUNT);

    logic [CLIENT_COUNT-1:0] req_bit;
    logic [CLIENT_COUNT-1:0] acq_waiters;
    logic [CLIENT_COUNT-1:0] rel_waiters;
    logic [CLIENT_COUNT-1:0] lowest_bit;
    logic [CW-1:0]           lowest_idx;

    assign req_bit     = CLIENT_COUNT'(1) << client;
    assign acq_waiters = cur_waiters & ~req_bit;
    assign rel_waiters = cur_waiters & ~req_bit;

    // Isolate and encode the lowest-numbered waiter left after a release
    assign lowest_bit = rel_waiters & (~rel_waiters + CLIENT_COUNT'(1));

    always_comb
    begin
        lowest_idx = '0;
        for (int i = 0; i < CLIENT_COUNT; i++)
        begin
            lowest_idx = lowest_idx | (lowest_bit[i] ? CW'(i) : CW'(0));
        end
    end

    // Decide the entry update and the answer
    always_comb
    begin
        new_exists  = cur_exists;
        new_held    = cur_held;
        new_owner   = cur_owner;
        new_waiters = cur_waiters;
        write_en    = 1'b0;
        code.status = ltm_pkg::ST_NOENT;
        code.kind   = ltm_pkg::MSG_NONE;
        target      = '0;
        if (in_range)
        begin
            if (opcode == ltm_pkg::OP_ACQUIRE)
            begin
                write_en   = 1'b1;
                new_exists = 1'b1;
                if (cur_exists && cur_held)
                begin
                    // Queue the requester and revoke from the holder
                    new_waiters = cur_waiters | req_bit;
                    code.status = ltm_pkg::ST_RETRY;
                    code.kind   = ltm_pkg::MSG_REVOKE;
                    target      = cur_owner;
                end
                else
                begin
                    // Grant, dequeue, revoke at once if others still wait
                    new_held    = 1'b1;
                    new_owner   = client;
                    new_waiters = acq_waiters;
                    code.status = ltm_pkg::ST_OK;
                    if (acq_waiters != '0)
                    begin
                        code.kind = ltm_pkg::MSG_REVOKE;
                        target    = client;
                    end
                end
            end
            else if (cur_exists && cur_held && cur_owner == client)
            begin
                // Free the lock and hand a retry to the lowest waiter
                write_en    = 1'b1;
                new_held    = 1'b0;
                new_waiters = rel_waiters & ~lowest_bit;
                code.status = ltm_pkg::ST_OK;
                if (rel_waiters != '0)
                begin
                    code.kind = ltm_pkg::MSG_RETRY;
                    target    = lowest_idx;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lock_table_manager.sv =====
// Top level of the lock table manager: request sequencer around the entry RAM.
//
//   channel   direction  handshake           payload
//   request   in         in_valid/in_stall   opcode, lock_index, client
//   result    out        out_valid/out_stall status, message_kind, message_target
//
// Each request is accepted in S_IDLE, which issues the RAM read; in S_MODIFY the
// registered read data is modified and the entry written back. After reset a
// clearing pass writes every entry with in_stall high. The result register
// holds a result while out_stall is high; a new request is accepted meanwhile
// and waits in its write phase.
`timescale 1ns / 1ps

module lock_table_manager #(
    parameter int LOCK_COUNT   = 64,
    parameter int CLIENT_COUNT = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            opcode,
    input  logic [$clog2(LOCK_COUNT)-1:0]   lock_index,
    input  logic [$clog2(CLIENT_COUNT)-1:0] client,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      status,
    output logic [1:0]                      message_kind,
    output logic [$clog2(CLIENT_COUNT)-1:0] message_target
);

    localparam int LW = $clog2(LOCK_COUNT);
    localparam int CW = $clog2(CLIENT_COUNT);
    localparam int EW = 2 + CW + CLIENT_COUNT;

    ltm_pkg::ltm_state_t state_reg, state_next;
    logic [LW-1:0] clr_idx_reg, clr_idx_next;

    logic          req_op_reg;
    logic [LW-1:0] req_lock_reg;
    logic [CW-1:0] req_client_reg;
    logic          req_range_reg;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg;
    logic [1:0]    kind_reg;
    logic [CW-1:0] target_reg;

    logic          in_xfer;
    logic          in_range;
    logic          load_out;

    logic          mem_we;
    logic [LW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [EW-1:0] mem_rdata;

    logic                    new_exists, new_held, upd_we;
    logic [CW-1:0]           new_owner, upd_target;
    logic [CLIENT_COUNT-1:0] new_waiters;
    ltm_pkg::result_code_t   upd_code;

    assign in_stall = (state_reg != ltm_pkg::S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign in_range = ({1'b0, lock_index} < (LW + 1)'(LOCK_COUNT))
                   && ({1'b0, client} < (CW + 1)'(CLIENT_COUNT));
    assign load_out = (state_reg == ltm_pkg::S_MODIFY) && (!out_valid_reg || !out_stall);

    // Entry store: {exists, held, owner, waiters}
    ltm_ram #(
        .WIDTH(EW),
        .DEPTH(LOCK_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_xfer),
        .raddr (lock_index),
        .rdata (mem_rdata)
    );

    ltm_update #(
        .CLIENT_COUNT(CLIENT_COUNT)
    ) u_update (
        .opcode      (req_op_reg),
        .in_range    (req_range_reg),
        .client      (req_client_reg),
        .cur_exists  (mem_rdata[EW-1]),
        .cur_held    (mem_rdata[EW-2]),
        .cur_owner   (mem_rdata[EW-3 -: CW]),
        .cur_waiters (mem_rdata[CLIENT_COUNT-1:0]),
        .new_exists  (new_exists),
        .new_held    (new_held),
        .new_owner   (new_owner),
        .new_waiters (new_waiters),
        .write_en    (upd_we),
        .code        (upd_code),
        .target      (upd_target)
    );

    // Select the write: clearing pass or write-back of the modified entry
    always_comb
    begin
        if (state_reg == ltm_pkg::S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = load_out && upd_we;
            mem_waddr = req_lock_reg;
            mem_wdata = {new_exists, new_held, new_owner, new_waiters};
        end
    end

    // Advance the sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            ltm_pkg::S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + LW'(1);
                if (clr_idx_reg == LW'(LOCK_COUNT - 1))
                begin
                    state_next = ltm_pkg::S_IDLE;
                end
            end
            ltm_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ltm_pkg::S_MODIFY;
                end
            end
            ltm_pkg::S_MODIFY:
            begin
                if (load_out)
                begin
                    state_next = ltm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ltm_pkg::S_CLEAR;
            end
        endcase
    end

    // Hold or drop the result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltm_pkg::S_CLEAR;
            clr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request on transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_op_reg     <= opcode;
            req_lock_reg   <= lock_index;
            req_client_reg <= client;
            req_range_reg  <= in_range;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg <= upd_code.status;
            kind_reg   <= upd_code.kind;
            target_reg <= upd_target;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign message_kind   = kind_reg;
    assign message_target = target_reg;

    // No request is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ltm_pkg::S_CLEAR) |-> in_stall)
        else $error("request accepted during clearing pass");

    // The table is written only by the clearing pass or a write-back
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ltm_pkg::S_CLEAR || load_out))
        else $error("stray table write");

    // An accepted request always moves to its modify cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ltm_pkg::S_MODIFY))
        else $error("accepted request lost its modify cycle");

    // A result appears only after a modify cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ltm_pkg::S_MODIFY))
        else $error("result without a request");

endmodule

// ===== test/lock_table_checker.sv =====
// Scoreboard of the lock table manager: predicts each reply and compares it with the DUT.
`timescale 1ns / 1ps

module lock_table_checker #(
    parameter int LOCK_COUNT   = 64,
    parameter int CLIENT_COUNT = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            opcode,
    input  logic [$clog2(LOCK_COUNT)-1:0]   lock_index,
    input  logic [$clog2(CLIENT_COUNT)-1:0] client,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [1:0]                      status,
    input  logic [1:0]                      message_kind,
    input  logic [$clog2(CLIENT_COUNT)-1:0] message_target,
    output int                              mismatch_count,
    output int                              replies_checked,
    output int                              replies_pending
);

    localparam int LW = $clog2(LOCK_COUNT);
    localparam int CW = $clog2(CLIENT_COUNT);

    typedef struct packed {
        logic [1:0]    status;
        logic [1:0]    kind;
        logic [CW-1:0] target;
    } lock_reply_t;

    // Shadow copy of the lock table
    logic                    lock_exists  [LOCK_COUNT];
    logic                    lock_held    [LOCK_COUNT];
    logic [CW-1:0]           lock_owner   [LOCK_COUNT];
    logic [CLIENT_COUNT-1:0] lock_waiters [LOCK_COUNT];

    // Replies predicted but not yet seen on the result channel
    lock_reply_t replies_due[$];

    // Apply one request to the shadow table and return the reply it causes
    function automatic lock_reply_t serve_request(input logic op, input logic [LW-1:0] lk,
                                                  input logic [CW-1:0] cl);
        lock_reply_t             reply;
        logic [CLIENT_COUNT-1:0] mask;
        logic                    found;
        reply = '{status: ltm_pkg::ST_NOENT, kind: ltm_pkg::MSG_NONE, target: '0};
        mask = '0;
        mask[cl] = 1'b1;
        found = 1'b0;
        if (int'(lk) >= LOCK_COUNT || int'(cl) >= CLIENT_COUNT)
            return reply;
        if (op == ltm_pkg::OP_ACQUIRE)
        begin
            // Create a missing entry free before deciding on the grant
            if (!lock_exists[lk])
            begin
                lock_exists[lk] = 1'b1;
                lock_held[lk]   = 1'b0;
                lock_owner[lk]  = cl;
            end
            if (lock_held[lk])
            begin
                // Queue the requester, holder included, and revoke from the holder
                lock_waiters[lk] = lock_waiters[lk] | mask;
                reply = '{status: ltm_pkg::ST_RETRY, kind: ltm_pkg::MSG_REVOKE,
                          target: lock_owner[lk]};
            end
            else
            begin
                // Grant; revoke at once when others still wait
                lock_held[lk]    = 1'b1;
                lock_owner[lk]   = cl;
                lock_waiters[lk] = lock_waiters[lk] & ~mask;
                if (lock_waiters[lk] != '0)
                    reply = '{status: ltm_pkg::ST_OK, kind: ltm_pkg::MSG_REVOKE, target: cl};
                else
                    reply = '{status: ltm_pkg::ST_OK, kind: ltm_pkg::MSG_NONE, target: '0};
            end
        end
        else if (lock_exists[lk] && lock_held[lk] && lock_owner[lk] == cl)
        begin
            // Free the lock and wake the lowest-numbered waiter
            lock_held[lk]    = 1'b0;
            lock_waiters[lk] = lock_waiters[lk] & ~mask;
            reply = '{status: ltm_pkg::ST_OK, kind: ltm_pkg::MSG_NONE, target: '0};
            for (int i = 0; i < CLIENT_COUNT; i++)
            begin
                if (!found && lock_waiters[lk][i])
                begin
                    found = 1'b1;
                    lock_waiters[lk][i] = 1'b0;
                    reply = '{status: ltm_pkg::ST_OK, kind: ltm_pkg::MSG_RETRY,
                              target: CW'(i)};
                end
            end
        end
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        lock_reply_t due;
        lock_reply_t seen;
        if (!rst_n)
        begin
            for (int i = 0; i < LOCK_COUNT; i++)
            begin
                lock_exists[i]  = 1'b0;
                lock_held[i]    = 1'b0;
                lock_owner[i]   = '0;
                lock_waiters[i] = '0;
            end
            replies_due.delete();
            mismatch_count  = 0;
            replies_checked = 0;
            replies_pending = 0;
        end
        else
        begin
            // Check a result transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                seen = '{status: status, kind: message_kind, target: message_target};
                if (replies_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected reply status %0d kind %0d target %0d",
                                 $realtime, seen.status, seen.kind, seen.target);
                    mismatch_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    replies_checked++;
                    if (seen.status !== due.status || seen.kind !== due.kind ||
                        seen.target !== due.target)
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: reply mismatch: expected %0d/%0d/%0d %s",
                                     $realtime, due.status, due.kind, due.target,
                                     $sformatf("got %0d/%0d/%0d",
                                               seen.status, seen.kind, seen.target));
                        mismatch_count++;
                    end
                end
            end
            // Predict the reply of a request transfer
            if (in_valid && !in_stall)
                replies_due.push_back(serve_request(opcode, lock_index, client));
            replies_pending = replies_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top of the lock table manager: stimulus, reset, idling and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int LOCK_COUNT    = 64;
    localparam int CLIENT_COUNT  = 16;
    localparam int LW            = $clog2(LOCK_COUNT);
    localparam int CW            = $clog2(CLIENT_COUNT);
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BLOCKS = 15;
    localparam int BLOCK_DRAWS   = 30;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            opcode;
    logic [$clog2(LOCK_COUNT)-1:0]   lock_index;
    logic [$clog2(CLIENT_COUNT)-1:0] client;
    logic                            out_valid;
    logic                            out_stall;
    logic [1:0]                      status;
    logic [1:0]                      message_kind;
    logic [$clog2(CLIENT_COUNT)-1:0] message_target;

    int   mismatch_count;
    int   replies_checked;
    int   replies_pending;
    int   requests_sent;
    int   cycle_count = 0;
    logic quiet;

    always #2 clk = ~clk;

    lock_table_manager #(
        .LOCK_COUNT   (LOCK_COUNT),
        .CLIENT_COUNT (CLIENT_COUNT)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .lock_index     (lock_index),
        .client         (client),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .message_kind   (message_kind),
        .message_target (message_target)
    );

    lock_table_checker #(
        .LOCK_COUNT   (LOCK_COUNT),
        .CLIENT_COUNT (CLIENT_COUNT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .lock_index      (lock_index),
        .client          (client),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .message_kind    (message_kind),
        .message_target  (message_target),
        .mismatch_count  (mismatch_count),
        .replies_checked (replies_checked),
        .replies_pending (replies_pending)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stall the result channel for a random count after each transfer
    initial
    begin : result_sink
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hold = quiet ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                hold = hold - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Drive one request after a random gap and hold it until the transfer
    task automatic send_request(input logic op, input logic [$clog2(LOCK_COUNT)-1:0] lk,
                                input logic [$clog2(CLIENT_COUNT)-1:0] cl);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        lock_index <= lk;
        client     <= cl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        requests_sent++;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                              mode;
        logic [$clog2(LOCK_COUNT)-1:0]   lk;
        logic [$clog2(CLIENT_COUNT)-1:0] cl;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = ltm_pkg::OP_ACQUIRE;
        lock_index    = '0;
        client        = '0;
        quiet         = 1'b0;
        requests_sent = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // First acquire creates and grants; holder and another client then queue
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd0);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd15);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd0);
        // Release by a non-holder and of a lock never created
        send_request(ltm_pkg::OP_RELEASE, 6'd0, 4'd15);
        send_request(ltm_pkg::OP_RELEASE, 6'd63, 4'd0);
        // Holder release drops itself from the waiters and wakes the other
        send_request(ltm_pkg::OP_RELEASE, 6'd0, 4'd0);
        send_request(ltm_pkg::OP_RELEASE, 6'd0, 4'd0);
        // Grant, queue two, wake the lowest, grant with a waiter left over
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd15);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd7);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd3);
        send_request(ltm_pkg::OP_RELEASE, 6'd0, 4'd15);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd0, 4'd3);
        send_request(ltm_pkg::OP_RELEASE, 6'd0, 4'd3);
        // Top lock, plus release by another client of an owned lock
        send_request(ltm_pkg::OP_ACQUIRE, 6'd63, 4'd15);
        send_request(ltm_pkg::OP_RELEASE, 6'd63, 4'd15);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd42, 4'd10);
        send_request(ltm_pkg::OP_RELEASE, 6'd42, 4'd5);
        send_request(ltm_pkg::OP_ACQUIRE, 6'd21, 4'd5);
        send_request(ltm_pkg::OP_RELEASE, 6'd42, 4'd10);

        // Random blocks: hot, mixed and full-range lock mixes
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            mode  = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BLOCK_DRAWS; n++)
            begin
                case (mode)
                    0:
                    begin
                        lk = LW'($urandom_range(0, 3));
                        cl = CW'($urandom_range(0, 3));
                    end
                    1:
                    begin
                        lk = LW'($urandom_range(0, 15));
                        cl = CW'($urandom_range(0, 15));
                    end
                    default:
                    begin
                        lk = LW'($urandom_range(0, LOCK_COUNT - 1));
                        cl = CW'($urandom_range(0, CLIENT_COUNT - 1));
                    end
                endcase
                // Acquire/release pairs by one client in four draws of ten, the rest loose requests
                if ($urandom_range(0, 9) < 4)
                begin
                    send_request(ltm_pkg::OP_ACQUIRE, lk, cl);
                    send_request(ltm_pkg::OP_RELEASE, lk, cl);
                end
                else
                    send_request($urandom_range(0, 1) ? ltm_pkg::OP_RELEASE
                                                      : ltm_pkg::OP_ACQUIRE, lk, cl);
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain the outstanding replies, then let the pipeline settle
        while (replies_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Covered %0d requests: directed grant, queue, revoke and release cases,",
                 requests_sent);
        $display("then random hot, mixed and full-range mixes; %0d replies compared",
                 replies_checked);
        if (mismatch_count == 0 && replies_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== lock_table_manager.f =====
rtl/core/ltm_pkg.sv
rtl/core/ltm_ram.sv
rtl/core/ltm_update.sv
rtl/core/lock_table_manager.sv
test/lock_table_checker.sv
test/tb.sv
